FILE: design/unft_pkg.sv
// ----------------------------------------------------------------------------
// unft_pkg
// Shared types and constants of the UDP NAT flow table.
// ----------------------------------------------------------------------------
package unft_pkg;

   typedef enum logic [3:0] {
      VERDICT_HIT       = 4'd0,
      VERDICT_CREATED   = 4'd1,
      VERDICT_MALFORMED = 4'd2,
      VERDICT_DHCP      = 4'd3,
      VERDICT_BCAST     = 4'd4,
      VERDICT_NO_TARGET = 4'd5,
      VERDICT_DONE      = 4'd6,
      VERDICT_REPLY     = 4'd7,
      VERDICT_IDLE_SLOT = 4'd8
   } verdict_type;

   typedef enum logic [1:0] {
      MODE_GUEST = 2'd0,
      MODE_TICK  = 2'd1,
      MODE_REPLY = 2'd2,
      MODE_CLEAR = 2'd3
   } mode_type;

   localparam logic [2:0] CSR_NET_ADDRESS = 3'd0;
   localparam logic [2:0] CSR_NET_MASK    = 3'd1;
   localparam logic [2:0] CSR_DNS_IP      = 3'd2;
   localparam logic [2:0] CSR_GATEWAY_IP  = 3'd3;
   localparam logic [2:0] CSR_RESOLVER_IP = 3'd4;
   localparam logic [2:0] CSR_DNS_IDLE    = 3'd5;
   localparam logic [2:0] CSR_FLOW_IDLE   = 3'd6;
   localparam logic [2:0] CSR_SWEEP_IVL   = 3'd7;

   localparam logic [31:0] LOOPBACK_IP = 32'h7f00_0001;
   localparam logic [15:0] PORT_DNS    = 16'd53;
   localparam logic [15:0] PORT_DHCP   = 16'd67;
   localparam logic [15:0] UDP_HDR_LEN = 16'd8;
   localparam logic [3:0]  MCAST_NIBBLE = 4'he;

   typedef struct packed {
      logic        dns;
      logic [15:0] gport;
      logic [31:0] rip;
      logic [15:0] rport;
      logic [31:0] seen;
   } entry_type;

endpackage

FILE: design/udp_nat_flow_table_unit.sv
// ----------------------------------------------------------------------------
// udp_nat_flow_table_unit
// NAT table of UDP flows with lookup, creation, oldest eviction, aging, reply refresh and clear.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one item (mode, time, datagram fields, reply slot) under
//   req_valid/req_ready. rsp_* returns exactly one result item per request
//   under rsp_valid/rsp_ready. csr_we/csr_index/csr_wdata write the eight
//   configuration registers. The user must write them only while the block is
//   idle; the block itself does not enforce this. Flow entries live in one
//   synchronous memory (one read and one write port, registered read); valid
//   bits sit in flip-flops. Drops, clears and early ticks end in the classify
//   state; a reply goes on to the reply state; a sweep or a new flow runs
//   classify, the scan over all slots and commit, and a hit reads the hit
//   entry again before it commits. One item is in work at a time; req_ready
//   returns the cycle after the result is taken, so no new item is accepted
//   before the last result is taken. Reset clears valid bits, last sweep
//   time and the registers to defaults; entry contents are not cleared.
//   A stalled rsp_ready holds the result.
// ----------------------------------------------------------------------------
module udp_nat_flow_table_unit #(
   parameter int FLOW_SLOTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic [31:0] req_now_ms,
   input  logic [15:0] req_guest_port,
   input  logic [31:0] req_remote_ip,
   input  logic [15:0] req_remote_port,
   input  logic [15:0] req_udp_length,
   input  logic [15:0] req_avail_length,
   input  logic [3:0]  req_reply_slot,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_verdict,
   output logic [3:0]  rsp_slot_index,
   output logic [31:0] rsp_target_ip,
   output logic [31:0] rsp_flow_remote_ip,
   output logic [15:0] rsp_flow_remote_port,
   output logic [15:0] rsp_flow_guest_port,
   output logic        rsp_flow_is_dns,
   output logic        rsp_evicted,
   output logic [15:0] rsp_closed_mask,
   output logic [15:0] rsp_payload_length,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int SW = (FLOW_SLOTS > 1) ? $clog2(FLOW_SLOTS) : 1;
   localparam int CW = $clog2(FLOW_SLOTS + 1);

   typedef enum logic [2:0] {
      ST_IDLE, ST_CLASSIFY, ST_SCAN, ST_REPLY, ST_COMMIT
   } state_type;

   state_type state_ff;

   logic [31:0] net_address_ff, net_mask_ff, dns_ip_ff, gateway_ip_ff;
   logic [31:0] resolver_ip_ff, dns_idle_ff, flow_idle_ff, sweep_ivl_ff;

   unft_pkg::entry_type mem [FLOW_SLOTS];
   unft_pkg::entry_type rd_data_ff;
   logic [SW-1:0]       rd_addr;
   logic                we;
   logic [SW-1:0]       wr_addr;
   unft_pkg::entry_type wr_data;

   logic [FLOW_SLOTS-1:0] valid_ff;
   logic [31:0]           last_sweep_ff;

   logic [1:0]  mode_ff;
   logic [31:0] now_ff, rip_ff;
   logic [15:0] gport_ff, rport_ff, ulen_ff, avail_ff;
   logic [3:0]  rslot_ff;

   logic [CW-1:0] scan_cnt_ff;
   logic          scan_data_ff;
   logic [SW-1:0] scan_idx_ff;
   logic          hit_ff;
   logic [SW-1:0] hit_idx_ff;
   logic          free_ff;
   logic [SW-1:0] free_idx_ff;
   logic [SW-1:0] old_idx_ff;
   logic [31:0]   old_seen_ff;
   logic          old_any_ff;
   logic [FLOW_SLOTS-1:0] close_ff;

   logic [3:0]  o_verdict_ff, o_slot_ff;
   logic [31:0] o_target_ff, o_rip_ff;
   logic [15:0] o_rport_ff, o_gport_ff, o_mask_ff, o_plen_ff;
   logic        o_dns_ff, o_evict_ff, rsp_valid_ff;

   assign req_ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   wire req_fire = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         net_address_ff <= 32'd167772672;
         net_mask_ff    <= 32'd4294967040;
         dns_ip_ff      <= 32'd167772675;
         gateway_ip_ff  <= 32'd167772674;
         resolver_ip_ff <= 32'd0;
         dns_idle_ff    <= 32'd10000;
         flow_idle_ff   <= 32'd60000;
         sweep_ivl_ff   <= 32'd1000;
      end else if (csr_we) begin
         unique case (csr_index)
            unft_pkg::CSR_NET_ADDRESS: net_address_ff <= csr_wdata;
            unft_pkg::CSR_NET_MASK:    net_mask_ff    <= csr_wdata;
            unft_pkg::CSR_DNS_IP:      dns_ip_ff      <= csr_wdata;
            unft_pkg::CSR_GATEWAY_IP:  gateway_ip_ff  <= csr_wdata;
            unft_pkg::CSR_RESOLVER_IP: resolver_ip_ff <= csr_wdata;
            unft_pkg::CSR_DNS_IDLE:    dns_idle_ff    <= csr_wdata;
            unft_pkg::CSR_FLOW_IDLE:   flow_idle_ff   <= csr_wdata;
            unft_pkg::CSR_SWEEP_IVL:   sweep_ivl_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (we) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   // Datagram classification
   logic malformed, is_dhcp, is_bcast, new_dns;
   logic [31:0] new_target;
   assign malformed = (avail_ff < unft_pkg::UDP_HDR_LEN) || (ulen_ff < unft_pkg::UDP_HDR_LEN)
                   || (ulen_ff > avail_ff);
   assign is_dhcp  = (rport_ff == unft_pkg::PORT_DHCP);
   assign is_bcast = (rip_ff == 32'hffff_ffff) || (rip_ff == (net_address_ff | ~net_mask_ff))
                   || (rip_ff[31:28] == unft_pkg::MCAST_NIBBLE);
   assign new_dns  = (rip_ff == dns_ip_ff) && (rport_ff == unft_pkg::PORT_DNS);
   assign new_target = new_dns ? resolver_ip_ff
                     : (rip_ff == gateway_ip_ff) ? unft_pkg::LOOPBACK_IP : rip_ff;

   logic sweep_due;
   logic [31:0] since_sweep;
   assign since_sweep = now_ff - last_sweep_ff;
   assign sweep_due   = !(since_sweep < sweep_ivl_ff);

   logic reply_ok;
   logic [SW-1:0] rslot_idx;
   assign rslot_idx = SW'(rslot_ff);
   assign reply_ok  = ({28'd0, rslot_ff} < 32'(FLOW_SLOTS)) && valid_ff[rslot_idx];

   // Scan compare on the entry read last cycle
   logic match, expired;
   logic [31:0] idle_t, ttl;
   assign match = valid_ff[scan_idx_ff] && (rd_data_ff.gport == gport_ff)
               && (rd_data_ff.rip == rip_ff) && (rd_data_ff.rport == rport_ff);
   assign idle_t  = now_ff - rd_data_ff.seen;
   assign ttl     = rd_data_ff.dns ? dns_idle_ff : flow_idle_ff;
   assign expired = valid_ff[scan_idx_ff] && (idle_t > ttl);

   // Commit decisions
   logic [SW-1:0] sel_idx;
   logic          need_evict;
   assign need_evict = !free_ff;
   assign sel_idx    = free_ff ? free_idx_ff : old_idx_ff;

   function automatic logic [31:0] target_of(input logic dns, input logic [31:0] ip,
                                              input logic [31:0] res, input logic [31:0] gw);
      target_of = dns ? res : (ip == gw) ? unft_pkg::LOOPBACK_IP : ip;
   endfunction

   function automatic logic [15:0] bit_mask(input logic [SW-1:0] s);
      logic [15:0] m;
      m = '0;
      if (32'(s) < 32'd16) m[4'(s)] = 1'b1;
      bit_mask = m;
   endfunction

   always_comb begin
      rd_addr = scan_cnt_ff[SW-1:0];
      if (state_ff == ST_CLASSIFY) rd_addr = rslot_idx;
      we = 1'b0;
      wr_addr = sel_idx;
      wr_data.dns   = new_dns;
      wr_data.gport = gport_ff;
      wr_data.rip   = rip_ff;
      wr_data.rport = rport_ff;
      wr_data.seen  = now_ff;
      if (state_ff == ST_REPLY) begin
         wr_addr = rslot_idx;
         wr_data = rd_data_ff;
         wr_data.seen = now_ff;
         we = reply_ok;
      end else if (state_ff == ST_COMMIT && mode_ff == unft_pkg::MODE_GUEST) begin
         if (hit_ff) begin
            wr_addr = hit_idx_ff;
            wr_data = rd_data_ff;
            wr_data.seen = now_ff;
            we = scan_data_ff;
         end else begin
            we = (new_target != 32'd0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         valid_ff      <= '0;
         last_sweep_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  mode_ff  <= req_mode;
                  now_ff   <= req_now_ms;
                  gport_ff <= req_guest_port;
                  rip_ff   <= req_remote_ip;
                  rport_ff <= req_remote_port;
                  ulen_ff  <= req_udp_length;
                  avail_ff <= req_avail_length;
                  rslot_ff <= req_reply_slot;
                  state_ff <= ST_CLASSIFY;
               end
            end
            ST_CLASSIFY: begin
               o_verdict_ff <= unft_pkg::VERDICT_DONE;
               o_slot_ff    <= '0;
               o_target_ff  <= '0;
               o_rip_ff     <= '0;
               o_rport_ff   <= '0;
               o_gport_ff   <= '0;
               o_dns_ff     <= 1'b0;
               o_evict_ff   <= 1'b0;
               o_mask_ff    <= '0;
               o_plen_ff    <= '0;
               scan_cnt_ff  <= '0;
               scan_data_ff <= 1'b0;
               hit_ff       <= 1'b0;
               free_ff      <= 1'b0;
               old_any_ff   <= 1'b0;
               close_ff     <= '0;
               unique case (unft_pkg::mode_type'(mode_ff))
                  unft_pkg::MODE_CLEAR: begin
                     o_mask_ff    <= 16'(valid_ff);
                     valid_ff     <= '0;
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= ST_IDLE;
                  end
                  unft_pkg::MODE_TICK: begin
                     if (sweep_due) begin
                        last_sweep_ff <= now_ff;
                        state_ff      <= ST_SCAN;
                     end else begin
                        rsp_valid_ff <= 1'b1;
                        state_ff     <= ST_IDLE;
                     end
                  end
                  unft_pkg::MODE_REPLY: state_ff <= ST_REPLY;
                  unft_pkg::MODE_GUEST: begin
                     if (malformed) begin
                        o_verdict_ff <= unft_pkg::VERDICT_MALFORMED;
                        rsp_valid_ff <= 1'b1;
                        state_ff     <= ST_IDLE;
                     end else begin
                        o_plen_ff <= ulen_ff - unft_pkg::UDP_HDR_LEN;
                        if (is_dhcp || is_bcast) begin
                           o_verdict_ff <= is_dhcp ? unft_pkg::VERDICT_DHCP
                                                   : unft_pkg::VERDICT_BCAST;
                           rsp_valid_ff <= 1'b1;
                           state_ff     <= ST_IDLE;
                        end else begin
                           state_ff <= ST_SCAN;
                        end
                     end
                  end
                  default: state_ff <= ST_IDLE;
               endcase
            end
            ST_REPLY: begin
               if (reply_ok) begin
                  o_verdict_ff <= unft_pkg::VERDICT_REPLY;
                  o_slot_ff    <= rslot_ff;
                  o_target_ff  <= target_of(rd_data_ff.dns, rd_data_ff.rip,
                                            resolver_ip_ff, gateway_ip_ff);
                  o_rip_ff     <= rd_data_ff.rip;
                  o_rport_ff   <= rd_data_ff.rport;
                  o_gport_ff   <= rd_data_ff.gport;
                  o_dns_ff     <= rd_data_ff.dns;
               end else begin
                  o_verdict_ff <= unft_pkg::VERDICT_IDLE_SLOT;
               end
               rsp_valid_ff <= 1'b1;
               state_ff     <= ST_IDLE;
            end
            ST_SCAN: begin
               if (scan_cnt_ff != CW'(FLOW_SLOTS)) scan_cnt_ff <= scan_cnt_ff + 1'b1;
               scan_idx_ff  <= scan_cnt_ff[SW-1:0];
               scan_data_ff <= (scan_cnt_ff != CW'(FLOW_SLOTS));
               if (scan_data_ff) begin
                  if (mode_ff == unft_pkg::MODE_TICK) begin
                     close_ff[scan_idx_ff] <= expired;
                  end else begin
                     if (match && !hit_ff) begin
                        hit_ff     <= 1'b1;
                        hit_idx_ff <= scan_idx_ff;
                     end
                     if (!valid_ff[scan_idx_ff] && !free_ff) begin
                        free_ff     <= 1'b1;
                        free_idx_ff <= scan_idx_ff;
                     end
                     if (!old_any_ff || rd_data_ff.seen < old_seen_ff) begin
                        old_any_ff  <= 1'b1;
                        old_idx_ff  <= scan_idx_ff;
                        old_seen_ff <= rd_data_ff.seen;
                     end
                  end
               end
               if (scan_data_ff && scan_cnt_ff == CW'(FLOW_SLOTS)) begin
                  state_ff <= ST_COMMIT;
                  if (mode_ff == unft_pkg::MODE_GUEST) begin
                     if (match && !hit_ff) scan_cnt_ff <= CW'(scan_idx_ff);
                     else if (hit_ff) scan_cnt_ff <= CW'(hit_idx_ff);
                  end
               end
            end
            ST_COMMIT: begin
               if (mode_ff == unft_pkg::MODE_TICK) begin
                  valid_ff     <= valid_ff & ~close_ff;
                  o_mask_ff    <= 16'(close_ff);
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end else if (hit_ff && !scan_data_ff) begin
                  // wait for the re-read of the hit entry
                  scan_data_ff <= 1'b1;
               end else if (hit_ff) begin
                  o_verdict_ff <= unft_pkg::VERDICT_HIT;
                  o_slot_ff    <= 4'(hit_idx_ff);
                  o_target_ff  <= target_of(rd_data_ff.dns, rd_data_ff.rip,
                                            resolver_ip_ff, gateway_ip_ff);
                  o_rip_ff     <= rd_data_ff.rip;
                  o_rport_ff   <= rd_data_ff.rport;
                  o_gport_ff   <= rd_data_ff.gport;
                  o_dns_ff     <= rd_data_ff.dns;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end else begin
                  o_evict_ff <= need_evict;
                  o_mask_ff  <= need_evict ? bit_mask(old_idx_ff) : 16'd0;
                  if (new_target == 32'd0) begin
                     o_verdict_ff <= unft_pkg::VERDICT_NO_TARGET;
                     if (need_evict) valid_ff[old_idx_ff] <= 1'b0;
                  end else begin
                     o_verdict_ff <= unft_pkg::VERDICT_CREATED;
                     valid_ff[sel_idx] <= 1'b1;
                     o_slot_ff   <= 4'(sel_idx);
                     o_target_ff <= new_target;
                     o_rip_ff    <= rip_ff;
                     o_rport_ff  <= rport_ff;
                     o_gport_ff  <= gport_ff;
                     o_dns_ff    <= new_dns;
                  end
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_verdict          = o_verdict_ff;
   assign rsp_slot_index       = o_slot_ff;
   assign rsp_target_ip        = o_target_ff;
   assign rsp_flow_remote_ip   = o_rip_ff;
   assign rsp_flow_remote_port = o_rport_ff;
   assign rsp_flow_guest_port  = o_gport_ff;
   assign rsp_flow_is_dns      = o_dns_ff;
   assign rsp_evicted          = o_evict_ff;
   assign rsp_closed_mask      = o_mask_ff;
   assign rsp_payload_length   = o_plen_ff;

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ready)
      else $error("second item accepted while one is in work");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_verdict))
      else $error("result dropped under stall");
   a_evict_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_evicted |-> $countones(rsp_closed_mask) <= 1)
      else $error("eviction closed more than one slot");
   a_no_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> !req_ready)
      else $error("ready during scan");

endmodule

FILE: test/tb_udp_nat_flow_table_unit.sv
// ----------------------------------------------------------------------------
// tb_udp_nat_flow_table_unit
// Self-checking bench for the UDP NAT flow table: directed datagrams, ticks,
// replies and clears, table eviction, register settings and random traffic
// under handshake stalls, each result checked against a built-in predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_udp_nat_flow_table_unit;

   localparam int SLOTS = 16;

   typedef struct packed {
      unft_pkg::mode_type mode;
      logic [31:0] now;
      logic [15:0] gport;
      logic [31:0] rip;
      logic [15:0] rport;
      logic [15:0] ulen;
      logic [15:0] avail;
      logic [3:0]  rslot;
   } flow_req_type;

   typedef struct packed {
      unft_pkg::verdict_type verdict;
      logic [3:0]  slot;
      logic [31:0] target;
      logic [31:0] fip;
      logic [15:0] fport;
      logic [15:0] fgport;
      logic        dns;
      logic        evicted;
      logic [15:0] closed;
      logic [15:0] plen;
   } flow_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_mode = '0;
   logic [31:0] req_now_ms = '0;
   logic [15:0] req_guest_port = '0;
   logic [31:0] req_remote_ip = '0;
   logic [15:0] req_remote_port = '0;
   logic [15:0] req_udp_length = '0;
   logic [15:0] req_avail_length = '0;
   logic [3:0]  req_reply_slot = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [3:0]  rsp_verdict;
   logic [3:0]  rsp_slot_index;
   logic [31:0] rsp_target_ip;
   logic [31:0] rsp_flow_remote_ip;
   logic [15:0] rsp_flow_remote_port;
   logic [15:0] rsp_flow_guest_port;
   logic        rsp_flow_is_dns;
   logic        rsp_evicted;
   logic [15:0] rsp_closed_mask;
   logic [15:0] rsp_payload_length;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   udp_nat_flow_table_unit dut (.*);

   // predictor state
   logic [31:0] cfg [8];
   logic        tbl_valid [SLOTS];
   logic        tbl_dns [SLOTS];
   logic [15:0] tbl_gport [SLOTS];
   logic [31:0] tbl_rip [SLOTS];
   logic [15:0] tbl_rport [SLOTS];
   logic [31:0] tbl_seen [SLOTS];
   logic [31:0] last_sweep;

   flow_rsp_type pending_q [$];
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          hold_req = 0;
   int          hold_ack = 0;
   int          hold_cycles = 0;
   int          error_count = 0;
   int          verdict_count [9];
   int          slots_closed = 0;
   logic [31:0] clock_ms = 32'd0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #5ms;
      $display("tb_udp_nat_flow_table_unit: done, errors");
      $finish;
   end

   always @(posedge clock) begin
      if (hold_req != hold_ack) begin
         hold_ack    <= hold_req;
         hold_cycles <= 400;
         rsp_ready   <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_ready   <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   function automatic logic [31:0] real_target(logic dns, logic [31:0] ip);
      if (dns) return cfg[unft_pkg::CSR_RESOLVER_IP];
      if (ip == cfg[unft_pkg::CSR_GATEWAY_IP]) return unft_pkg::LOOPBACK_IP;
      return ip;
   endfunction

   function automatic flow_rsp_type slot_view(flow_rsp_type r, int s);
      r.slot   = s[3:0];
      r.target = real_target(tbl_dns[s], tbl_rip[s]);
      r.fip    = tbl_rip[s];
      r.fport  = tbl_rport[s];
      r.fgport = tbl_gport[s];
      r.dns    = tbl_dns[s];
      return r;
   endfunction

   function automatic flow_rsp_type predict_flow(flow_req_type q);
      flow_rsp_type r;
      logic [31:0] ttl;
      logic        dns;
      logic [31:0] t;
      int          s;
      r = '0;
      r.verdict = unft_pkg::VERDICT_DONE;
      case (q.mode)
         unft_pkg::MODE_CLEAR: begin
            for (int i = 0; i < SLOTS; i++) begin
               r.closed[i] = tbl_valid[i];
               tbl_valid[i] = 1'b0;
            end
            return r;
         end
         unft_pkg::MODE_TICK: begin
            if (q.now - last_sweep < cfg[unft_pkg::CSR_SWEEP_IVL]) return r;
            last_sweep = q.now;
            for (int i = 0; i < SLOTS; i++) begin
               ttl = tbl_dns[i] ? cfg[unft_pkg::CSR_DNS_IDLE] : cfg[unft_pkg::CSR_FLOW_IDLE];
               if (tbl_valid[i] && (q.now - tbl_seen[i]) > ttl) begin
                  tbl_valid[i] = 1'b0;
                  r.closed[i] = 1'b1;
               end
            end
            return r;
         end
         unft_pkg::MODE_REPLY: begin
            if (!tbl_valid[q.rslot]) begin
               r.verdict = unft_pkg::VERDICT_IDLE_SLOT;
               return r;
            end
            tbl_seen[q.rslot] = q.now;
            r.verdict = unft_pkg::VERDICT_REPLY;
            return slot_view(r, q.rslot);
         end
         default: ;
      endcase
      if (q.avail < unft_pkg::UDP_HDR_LEN || q.ulen < unft_pkg::UDP_HDR_LEN
          || q.ulen > q.avail) begin
         r.verdict = unft_pkg::VERDICT_MALFORMED;
         return r;
      end
      r.plen = q.ulen - unft_pkg::UDP_HDR_LEN;
      if (q.rport == unft_pkg::PORT_DHCP) begin
         r.verdict = unft_pkg::VERDICT_DHCP;
         return r;
      end
      if (q.rip == 32'hffff_ffff
          || q.rip == (cfg[unft_pkg::CSR_NET_ADDRESS] | ~cfg[unft_pkg::CSR_NET_MASK])
          || q.rip[31:28] == unft_pkg::MCAST_NIBBLE) begin
         r.verdict = unft_pkg::VERDICT_BCAST;
         return r;
      end
      for (int i = 0; i < SLOTS; i++) begin
         if (tbl_valid[i] && tbl_gport[i] == q.gport && tbl_rip[i] == q.rip
             && tbl_rport[i] == q.rport) begin
            tbl_seen[i] = q.now;
            r.verdict = unft_pkg::VERDICT_HIT;
            return slot_view(r, i);
         end
      end
      s = -1;
      for (int i = 0; i < SLOTS; i++) begin
         if (!tbl_valid[i] && s < 0) s = i;
      end
      if (s < 0) begin
         s = 0;
         for (int i = 1; i < SLOTS; i++) begin
            if (tbl_seen[i] < tbl_seen[s]) s = i;
         end
         tbl_valid[s] = 1'b0;
         r.evicted = 1'b1;
         r.closed[s] = 1'b1;
      end
      dns = (q.rip == cfg[unft_pkg::CSR_DNS_IP]) && (q.rport == unft_pkg::PORT_DNS);
      t = real_target(dns, q.rip);
      if (t == 32'd0) begin
         r.verdict = unft_pkg::VERDICT_NO_TARGET;
         return r;
      end
      tbl_valid[s] = 1'b1;
      tbl_dns[s]   = dns;
      tbl_gport[s] = q.gport;
      tbl_rip[s]   = q.rip;
      tbl_rport[s] = q.rport;
      tbl_seen[s]  = q.now;
      r.verdict = unft_pkg::VERDICT_CREATED;
      return slot_view(r, s);
   endfunction

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         error_count++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      flow_rsp_type w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_q.size() == 0) begin
            error_count++;
            $display("%0t: result item with none expected, expected none, actual verdict %h",
                     $time, rsp_verdict);
         end else begin
            w = pending_q.pop_front();
            check_field("verdict", w.verdict, rsp_verdict);
            check_field("slot_index", w.slot, rsp_slot_index);
            check_field("target_ip", w.target, rsp_target_ip);
            check_field("flow_remote_ip", w.fip, rsp_flow_remote_ip);
            check_field("flow_remote_port", w.fport, rsp_flow_remote_port);
            check_field("flow_guest_port", w.fgport, rsp_flow_guest_port);
            check_field("flow_is_dns", w.dns, rsp_flow_is_dns);
            check_field("evicted", w.evicted, rsp_evicted);
            check_field("closed_mask", w.closed, rsp_closed_mask);
            check_field("payload_length", w.plen, rsp_payload_length);
         end
      end
   end

   task automatic send_item(flow_req_type q);
      flow_rsp_type r;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_mode         <= q.mode;
      req_now_ms       <= q.now;
      req_guest_port   <= q.gport;
      req_remote_ip    <= q.rip;
      req_remote_port  <= q.rport;
      req_udp_length   <= q.ulen;
      req_avail_length <= q.avail;
      req_reply_slot   <= q.rslot;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      r = predict_flow(q);
      verdict_count[r.verdict]++;
      slots_closed += $countones(r.closed);
      pending_q.push_back(r);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_q.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] idx, logic [31:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      cfg[idx] = val;
      @(posedge clock);
   endtask

   function automatic flow_req_type guest(logic [31:0] now, logic [15:0] gp, logic [31:0] ip,
                                          logic [15:0] rp, logic [15:0] ul, logic [15:0] av);
      flow_req_type q;
      q = '0;
      q.mode = unft_pkg::MODE_GUEST;
      q.now = now; q.gport = gp; q.rip = ip; q.rport = rp; q.ulen = ul; q.avail = av;
      return q;
   endfunction

   function automatic flow_req_type control(unft_pkg::mode_type m, logic [31:0] now,
                                            logic [3:0] s);
      flow_req_type q;
      q = '0;
      q.mode = m; q.now = now; q.rslot = s;
      return q;
   endfunction

   function automatic flow_req_type random_item();
      flow_req_type q;
      int           pick;
      q.gport = ($urandom_range(9) < 7) ? 16'(1000 + $urandom_range(5)) : 16'($urandom);
      pick = $urandom_range(99);
      if (pick < 45)      q.rip = 32'h0808_0800 + $urandom_range(3);
      else if (pick < 55) q.rip = cfg[unft_pkg::CSR_DNS_IP];
      else if (pick < 63) q.rip = cfg[unft_pkg::CSR_GATEWAY_IP];
      else if (pick < 66) q.rip = cfg[unft_pkg::CSR_NET_ADDRESS] | ~cfg[unft_pkg::CSR_NET_MASK];
      else if (pick < 69) q.rip = {unft_pkg::MCAST_NIBBLE, 28'($urandom)};
      else if (pick < 71) q.rip = 32'hffff_ffff;
      else                q.rip = $urandom;
      pick = $urandom_range(99);
      if (pick < 40)      q.rport = unft_pkg::PORT_DNS;
      else if (pick < 44) q.rport = unft_pkg::PORT_DHCP;
      else if (pick < 80) q.rport = 16'(5000 + $urandom_range(2));
      else                q.rport = 16'($urandom);
      if ($urandom_range(99) < 8) begin
         q.ulen  = 16'($urandom_range(20));
         q.avail = ($urandom_range(1)) ? 16'($urandom) : 16'($urandom_range(20));
      end else begin
         q.avail = ($urandom_range(9) == 0) ? 16'($urandom_range(8, 65535))
                                            : 16'($urandom_range(8, 1500));
         q.ulen  = 16'($urandom_range(8, q.avail));
      end
      q.rslot = 4'($urandom);
      pick = $urandom_range(99);
      if (pick < 3)       clock_ms = $urandom;
      else if (pick < 20) clock_ms += $urandom_range(20000);
      else                clock_ms += $urandom_range(400);
      q.now = clock_ms;
      pick = $urandom_range(99);
      if (pick < 68)      q.mode = unft_pkg::MODE_GUEST;
      else if (pick < 82) q.mode = unft_pkg::MODE_TICK;
      else if (pick < 98) q.mode = unft_pkg::MODE_REPLY;
      else                q.mode = unft_pkg::MODE_CLEAR;
      return q;
   endfunction

   task automatic test_directed;
      send_item(guest(32'd10, 16'd1, 32'h0101_0101, 16'd9, 16'd7, 16'd7));
      send_item(guest(32'd10, 16'd1, 32'h0101_0101, 16'd9, 16'd0, 16'hffff));
      send_item(guest(32'd10, 16'd1, 32'h0101_0101, 16'd9, 16'd100, 16'd99));
      send_item(guest(32'd10, 16'd1, 32'h0101_0101, unft_pkg::PORT_DHCP, 16'hffff, 16'hffff));
      send_item(guest(32'd10, 16'd1, 32'hffff_ffff, 16'd9, 16'd8, 16'd8));
      send_item(guest(32'd10, 16'd1, 32'h0a00_02ff, 16'd9, 16'd8, 16'd8));
      send_item(guest(32'd10, 16'd1, 32'he000_0001, 16'd9, 16'd8, 16'd8));
      send_item(guest(32'd100, 16'd0, 32'h0102_0304, 16'd0, 16'd8, 16'd20));
      send_item(guest(32'd200, 16'd0, 32'h0102_0304, 16'd0, 16'd20, 16'd20));
      send_item(guest(32'd300, 16'hffff, cfg[unft_pkg::CSR_GATEWAY_IP], 16'hffff,
                      16'd64, 16'd64));
      send_item(guest(32'd300, 16'd7, cfg[unft_pkg::CSR_DNS_IP], unft_pkg::PORT_DNS,
                      16'd40, 16'd40));
      send_item(control(unft_pkg::MODE_REPLY, 32'd400, 4'd0));
      send_item(control(unft_pkg::MODE_REPLY, 32'd400, 4'd15));
      send_item(control(unft_pkg::MODE_TICK, 32'd500, 4'd0));
      send_item(control(unft_pkg::MODE_TICK, 32'd70000, 4'd0));
      send_item(control(unft_pkg::MODE_CLEAR, 32'd70000, 4'd0));
      send_item(control(unft_pkg::MODE_TICK, 32'hffff_ffff, 4'd0));
      drain();
   endtask

   task automatic test_eviction;
      for (int i = 0; i < SLOTS; i++)
         send_item(guest(32'd1000 + 32'(SLOTS - i), 16'(i), 32'h0909_0909, 16'd80,
                         16'd9, 16'd9));
      // full table, DNS flow without resolver: evict, then no target
      send_item(guest(32'd2000, 16'd77, cfg[unft_pkg::CSR_DNS_IP], unft_pkg::PORT_DNS,
                      16'd8, 16'd8));
      send_item(guest(32'd2001, 16'd78, 32'h0909_0909, 16'd81, 16'd8, 16'd8));
      send_item(guest(32'd2002, 16'd79, 32'h0909_0909, 16'd82, 16'd8, 16'd8));
      send_item(control(unft_pkg::MODE_CLEAR, 32'd2003, 4'd0));
      drain();
   endtask

   task automatic configure(int setting);
      case (setting)
         0: begin
            csr_write(unft_pkg::CSR_RESOLVER_IP, 32'h0101_0101);
            csr_write(unft_pkg::CSR_DNS_IDLE, 32'd500);
            csr_write(unft_pkg::CSR_FLOW_IDLE, 32'd2000);
            csr_write(unft_pkg::CSR_SWEEP_IVL, 32'd0);
         end
         1: begin
            csr_write(unft_pkg::CSR_NET_ADDRESS, 32'hffff_ffff);
            csr_write(unft_pkg::CSR_NET_MASK, 32'h0000_0000);
            csr_write(unft_pkg::CSR_DNS_IP, 32'h0000_0000);
            csr_write(unft_pkg::CSR_GATEWAY_IP, 32'hffff_fffe);
            csr_write(unft_pkg::CSR_RESOLVER_IP, 32'hffff_ffff);
            csr_write(unft_pkg::CSR_DNS_IDLE, 32'hffff_ffff);
            csr_write(unft_pkg::CSR_FLOW_IDLE, 32'd0);
            csr_write(unft_pkg::CSR_SWEEP_IVL, 32'hffff_ffff);
         end
         default: begin
            csr_write(unft_pkg::CSR_NET_ADDRESS, $urandom & 32'hffff_ff00);
            csr_write(unft_pkg::CSR_NET_MASK, 32'hffff_ff00);
            csr_write(unft_pkg::CSR_DNS_IP, 32'h0808_0800 + $urandom_range(3));
            csr_write(unft_pkg::CSR_GATEWAY_IP, 32'h0808_0800 + $urandom_range(3));
            csr_write(unft_pkg::CSR_RESOLVER_IP, ($urandom_range(2) == 0) ? 32'd0 : $urandom);
            csr_write(unft_pkg::CSR_DNS_IDLE, $urandom_range(3000));
            csr_write(unft_pkg::CSR_FLOW_IDLE, $urandom_range(8000));
            csr_write(unft_pkg::CSR_SWEEP_IVL, $urandom_range(1500));
         end
      endcase
      csr_we <= 1'b0;
   endtask

   task automatic test_random(int count, int s_idle, int r_idle);
      send_idle_pct = s_idle;
      recv_idle_pct = r_idle;
      for (int i = 0; i < count; i++) send_item(random_item());
      drain();
   endtask

   task automatic test_backpressure;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_req++;
      for (int i = 0; i < 12; i++) send_item(random_item());
      drain();
   endtask

   initial begin
      cfg[unft_pkg::CSR_NET_ADDRESS] = 32'h0a00_0200;
      cfg[unft_pkg::CSR_NET_MASK]    = 32'hffff_ff00;
      cfg[unft_pkg::CSR_DNS_IP]      = 32'h0a00_0203;
      cfg[unft_pkg::CSR_GATEWAY_IP]  = 32'h0a00_0202;
      cfg[unft_pkg::CSR_RESOLVER_IP] = 32'd0;
      cfg[unft_pkg::CSR_DNS_IDLE]    = 32'd10000;
      cfg[unft_pkg::CSR_FLOW_IDLE]   = 32'd60000;
      cfg[unft_pkg::CSR_SWEEP_IVL]   = 32'd1000;
      for (int i = 0; i < SLOTS; i++) tbl_valid[i] = 1'b0;
      last_sweep = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_eviction();
      test_random(300, 24, 87);
      configure(0);
      test_random(300, 87, 24);
      test_backpressure();
      configure(1);
      test_random(250, 0, 0);
      configure(2);
      test_random(350, 24, 87);
      configure(2);
      test_random(350, 87, 24);
      configure(0);
      test_random(300, 0, 0);
      $display("covered %0d hits, %0d creations, %0d no-target, %0d replies, %0d idle slots",
               verdict_count[unft_pkg::VERDICT_HIT], verdict_count[unft_pkg::VERDICT_CREATED],
               verdict_count[unft_pkg::VERDICT_NO_TARGET],
               verdict_count[unft_pkg::VERDICT_REPLY],
               verdict_count[unft_pkg::VERDICT_IDLE_SLOT]);
      $display("plus %0d drops, %0d done verdicts, %0d slots closed, over 4 register settings",
               verdict_count[unft_pkg::VERDICT_MALFORMED] + verdict_count[unft_pkg::VERDICT_DHCP]
               + verdict_count[unft_pkg::VERDICT_BCAST], verdict_count[unft_pkg::VERDICT_DONE],
               slots_closed);
      if (error_count == 0)
         $display("tb_udp_nat_flow_table_unit: done, clean");
      else
         $display("tb_udp_nat_flow_table_unit: done, errors");
      $finish;
   end

endmodule
